// ===== rtl/core/wual_pkg.sv =====
// ----------------------------------------------------------------------------
// wual_pkg
// Shared types, widths and level helpers of the antialiased line stepper.
// ----------------------------------------------------------------------------
package wual_pkg;

    localparam int COORD_BITS = 11;
    localparam int FRAC_BITS  = 16;
    localparam int LEVEL_BITS = 8;
    localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
    localparam int QUOT_BITS  = FRAC_BITS + 1;
    localparam int GRAD_BITS  = FRAC_BITS + 2;
    localparam int REM_BITS   = COORD_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(QUOT_BITS);

    localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = LEVEL_BITS'(100);

    localparam int CMD_DEPTH    = 2;
    localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH    = 2;
    localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_op_t;

    // classified command as it waits between front and back
    typedef struct packed {
        cmd_op_t op;
        logic    single;
        logic    axis;
        logic    steep;
        logic    neg;
        coord_t  num_mag;
        coord_t  den;
        coord_t  major0;
        coord_t  major1;
        coord_t  minor0;
        coord_t  final_x;
        coord_t  final_y;
    } cmd_t;

    typedef struct packed {
        coord_t                x;
        coord_t                y;
        logic [LEVEL_BITS-1:0] lvl;
        logic                  done;
    } res_t;

    typedef struct packed {
        logic   start;
        coord_t num_mag;
        coord_t den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [QUOT_BITS-1:0] quot;
    } div_rsp_t;

    // (255 * frac) >> FRAC_BITS
    function automatic logic [LEVEL_BITS-1:0] level_lo(input logic [FRAC_BITS-1:0] frac);
        logic [FRAC_BITS+LEVEL_BITS-1:0] prod;
        prod = {frac, LEVEL_BITS'(0)} - {LEVEL_BITS'(0), frac};
        return prod[FRAC_BITS+LEVEL_BITS-1:FRAC_BITS];
    endfunction

    // (255 * (2^FRAC_BITS - frac)) >> FRAC_BITS
    function automatic logic [LEVEL_BITS-1:0] level_hi(input logic [FRAC_BITS-1:0] frac);
        logic [FRAC_BITS:0]              inv;
        logic [FRAC_BITS+LEVEL_BITS:0]   prod;
        inv  = {1'b1, FRAC_BITS'(0)} - {1'b0, frac};
        prod = {inv, LEVEL_BITS'(0)} - {LEVEL_BITS'(0), inv};
        return prod[FRAC_BITS+LEVEL_BITS-1:FRAC_BITS];
    endfunction

endpackage

// ===== rtl/core/wual_front.sv =====
// ----------------------------------------------------------------------------
// wual_front
// Accepts commands, orders the endpoints along the major axis and queues the
// classified command for the back end.
// ----------------------------------------------------------------------------
module wual_front
    import wual_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    output logic   full,
    input  logic   command,
    input  coord_t start_x,
    input  coord_t start_y,
    input  coord_t end_x,
    input  coord_t end_y,
    output logic   cmd_valid,
    output cmd_t   cmd_head,
    input  logic   cmd_pop
);

    cmd_t                    slot_reg [CMD_DEPTH];
    logic [CMD_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_BITS-1:0] count_reg, count_next;

    logic   dx_neg, dy_neg, steep, swap_ends;
    coord_t adx, ady, sx0, sy0, sx1, sy1, minor1;
    cmd_t   cls;
    logic   wr_en, rd_en;

    always_comb
    begin
        dx_neg    = end_x < start_x;
        dy_neg    = end_y < start_y;
        adx       = dx_neg ? start_x - end_x : end_x - start_x;
        ady       = dy_neg ? start_y - end_y : end_y - start_y;
        // equal slopes and vertical lines go the steep way
        steep     = ady >= adx;
        swap_ends = steep ? dy_neg : dx_neg;
        sx0       = swap_ends ? end_x   : start_x;
        sy0       = swap_ends ? end_y   : start_y;
        sx1       = swap_ends ? start_x : end_x;
        sy1       = swap_ends ? start_y : end_y;
        minor1    = steep ? sx1 : sy1;

        cls.op      = cmd_op_t'(command);
        cls.single  = (adx == '0) && (ady == '0);
        cls.axis    = (adx == '0) || (ady == '0);
        cls.steep   = steep;
        cls.major0  = steep ? sy0 : sx0;
        cls.major1  = steep ? sy1 : sx1;
        cls.minor0  = steep ? sx0 : sy0;
        cls.neg     = minor1 < cls.minor0;
        cls.num_mag = steep ? adx : ady;
        cls.den     = steep ? ady : adx;
        cls.final_x = sx1;
        cls.final_y = sy1;
    end

    assign full      = count_reg == CMD_CNT_BITS'(CMD_DEPTH);
    assign cmd_valid = count_reg != '0;
    assign cmd_head  = slot_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_BITS'(CMD_DEPTH - 1)) ? '0
                        : wr_ptr_reg + CMD_PTR_BITS'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_BITS'(CMD_DEPTH - 1)) ? '0
                        : rd_ptr_reg + CMD_PTR_BITS'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CMD_CNT_BITS'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CMD_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/core/wual_div.sv =====
// ----------------------------------------------------------------------------
// wual_div
// Restoring divider for the gradient: (num_mag << FRAC_BITS) / den, one
// quotient bit per cycle, num_mag never above den.
// ----------------------------------------------------------------------------
module wual_div
    import wual_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [REM_BITS-1:0]     rem_reg, rem_next;
    coord_t                  den_reg, den_next;
    logic [QUOT_BITS-1:0]    quot_reg, quot_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;

    logic [REM_BITS-1:0] trial;
    logic                ge;

    always_comb
    begin
        // integer bit first without a shift, then one fraction bit a cycle
        trial = (cnt_reg == '0) ? rem_reg : {rem_reg[REM_BITS-2:0], 1'b0};
        ge    = trial >= {1'b0, den_reg};

        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = {1'b0, req.num_mag};
            den_next  = req.den;
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? trial - {1'b0, den_reg} : trial;
            quot_next = {quot_reg[QUOT_BITS-2:0], ge};
            cnt_next  = cnt_reg + DIV_CNT_BITS'(1);
            if (cnt_reg == DIV_CNT_BITS'(QUOT_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ===== rtl/core/wual_back.sv =====
// ----------------------------------------------------------------------------
// wual_back
// Line state and stepping: takes classified commands, runs the gradient
// division on a sloped start and writes pixels to the result queue.
// ----------------------------------------------------------------------------
module wual_back
    import wual_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [LEVEL_BITS-1:0] cfg_level,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd_head,
    output logic                  cmd_pop,
    output div_req_t              div_req,
    input  div_rsp_t              div_rsp,
    input  logic                  out_full,
    output logic                  out_wr,
    output res_t                  out_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_FIRST = 4'b0100,
        ST_PIX2  = 4'b1000
    } back_state_t;

    back_state_t          state_reg, state_next;
    logic                 active_reg, active_next;
    logic                 steep_reg, steep_next;
    logic                 axis_reg, axis_next;
    logic                 single_reg, single_next;
    logic                 neg_reg, neg_next;
    coord_t               major_pos_reg, major_pos_next;
    coord_t               major_end_reg, major_end_next;
    coord_t               minor0_reg, minor0_next;
    coord_t               final_x_reg, final_x_next;
    coord_t               final_y_reg, final_y_next;
    logic [ACC_BITS-1:0]  accum_reg, accum_next;
    logic [GRAD_BITS-1:0] grad_reg, grad_next;

    logic                 acc_neg;
    coord_t               mnr, major_inc;
    logic [FRAC_BITS-1:0] frac;
    logic [GRAD_BITS-1:0] quot_ext;
    logic [ACC_BITS-1:0]  grad_ext, accum_base;

    function automatic res_t make_pix(input logic steep, input coord_t major,
                                      input coord_t minor,
                                      input logic [LEVEL_BITS-1:0] lvl,
                                      input logic done);
        res_t r;
        r.x    = steep ? minor : major;
        r.y    = steep ? major : minor;
        r.lvl  = lvl;
        r.done = done;
        return r;
    endfunction

    always_comb
    begin
        acc_neg    = accum_reg[ACC_BITS-1];
        mnr        = acc_neg ? '0 : accum_reg[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
        frac       = acc_neg ? '0 : accum_reg[FRAC_BITS-1:0];
        major_inc  = major_pos_reg + COORD_BITS'(1);
        quot_ext   = {1'b0, div_rsp.quot};
        grad_ext   = {{(ACC_BITS-GRAD_BITS){grad_reg[GRAD_BITS-1]}}, grad_reg};
        accum_base = {1'b0, minor0_reg, FRAC_BITS'(0)};

        state_next     = state_reg;
        active_next    = active_reg;
        steep_next     = steep_reg;
        axis_next      = axis_reg;
        single_next    = single_reg;
        neg_next       = neg_reg;
        major_pos_next = major_pos_reg;
        major_end_next = major_end_reg;
        minor0_next    = minor0_reg;
        final_x_next   = final_x_reg;
        final_y_next   = final_y_reg;
        accum_next     = accum_reg;
        grad_next      = grad_reg;
        cmd_pop        = 1'b0;
        div_req        = '0;
        out_wr         = 1'b0;
        out_data       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd_head.op == CMD_START)
                    begin
                        cmd_pop        = 1'b1;
                        steep_next     = cmd_head.steep;
                        axis_next      = cmd_head.axis;
                        single_next    = cmd_head.single;
                        neg_next       = cmd_head.neg;
                        major_pos_next = cmd_head.major0;
                        major_end_next = cmd_head.major1;
                        minor0_next    = cmd_head.minor0;
                        final_x_next   = cmd_head.final_x;
                        final_y_next   = cmd_head.final_y;
                        grad_next      = '0;
                        if (cmd_head.axis)
                        begin
                            state_next = ST_FIRST;
                        end
                        else
                        begin
                            div_req.start   = 1'b1;
                            div_req.num_mag = cmd_head.num_mag;
                            div_req.den     = cmd_head.den;
                            state_next      = ST_DIV;
                        end
                    end
                    else if (!active_reg)
                    begin
                        // step with no line in progress is dropped
                        cmd_pop = 1'b1;
                    end
                    else if (!out_full)
                    begin
                        cmd_pop        = 1'b1;
                        major_pos_next = major_inc;
                        out_wr         = 1'b1;
                        if (major_inc >= major_end_reg)
                        begin
                            active_next = 1'b0;
                            out_data    = '{x: final_x_reg, y: final_y_reg,
                                            lvl: cfg_level, done: 1'b1};
                        end
                        else if (axis_reg)
                        begin
                            out_data = make_pix(steep_reg, major_inc, mnr, cfg_level, 1'b0);
                        end
                        else
                        begin
                            out_data   = make_pix(steep_reg, major_inc, mnr,
                                                  level_lo(frac), 1'b0);
                            state_next = ST_PIX2;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    grad_next  = neg_reg ? -quot_ext : quot_ext;
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if (!out_full)
                begin
                    out_wr      = 1'b1;
                    out_data    = make_pix(steep_reg, major_pos_reg, minor0_reg,
                                           cfg_level, single_reg);
                    active_next = !single_reg;
                    accum_next  = accum_base + grad_ext;
                    state_next  = ST_IDLE;
                end
            end
            ST_PIX2:
            begin
                if (!out_full)
                begin
                    // neighbour above the floor pixel, wraps in the coordinate width
                    out_wr     = 1'b1;
                    out_data   = make_pix(steep_reg, major_pos_reg, mnr + COORD_BITS'(1),
                                          level_hi(frac), 1'b0);
                    accum_next = accum_reg + grad_ext;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            steep_reg     <= 1'b0;
            axis_reg      <= 1'b0;
            single_reg    <= 1'b0;
            major_pos_reg <= '0;
            major_end_reg <= '0;
            accum_reg     <= '0;
            grad_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            steep_reg     <= steep_next;
            axis_reg      <= axis_next;
            single_reg    <= single_next;
            major_pos_reg <= major_pos_next;
            major_end_reg <= major_end_next;
            accum_reg     <= accum_next;
            grad_reg      <= grad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        minor0_reg  <= minor0_next;
        final_x_reg <= final_x_next;
        final_y_reg <= final_y_next;
    end

endmodule

// ===== rtl/core/wual_out_fifo.sv =====
// ----------------------------------------------------------------------------
// wual_out_fifo
// Small result queue between the back end and the pop side.
// ----------------------------------------------------------------------------
module wual_out_fifo
    import wual_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  res_t wr_data,
    output logic out_full,
    output logic empty,
    input  logic pop,
    output res_t rd_data
);

    res_t                    slot_reg [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_BITS-1:0] count_reg, count_next;
    logic                    wr_en, rd_en;

    assign out_full = count_reg == OUT_CNT_BITS'(OUT_DEPTH);
    assign empty    = count_reg == '0;
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign wr_en    = wr && !out_full;
    assign rd_en    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == OUT_PTR_BITS'(OUT_DEPTH - 1)) ? '0
                        : wr_ptr_reg + OUT_PTR_BITS'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == OUT_PTR_BITS'(OUT_DEPTH - 1)) ? '0
                        : rd_ptr_reg + OUT_PTR_BITS'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + OUT_CNT_BITS'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - OUT_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/wu_antialiased_line_stepper.sv =====
// path: a step's pixel goes through the command queue, then the result queue, to the
// result ports; a start's first pixel also goes through the back end's first-pixel state, and
// a sloped start waits for the serial gradient divider. A step writes one axis or end pixel
// or a pixel pair through the result queue's one-pixel-per-cycle write port, while not full
// reset: rst_n is asynchronous, active low; queues empty, no line active,
// endpoint level back to 100
// ----------------------------------------------------------------------------
// wu_antialiased_line_stepper
// Antialiased line stepper: command queue front end, stepping back end with a
// serial gradient divider, and a result queue.
// ----------------------------------------------------------------------------
module wu_antialiased_line_stepper
    import wual_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [LEVEL_BITS-1:0] cfg_wdata,
    input  logic                  push,
    output logic                  full,
    input  logic                  command,
    input  coord_t                start_x,
    input  coord_t                start_y,
    input  coord_t                end_x,
    input  coord_t                end_y,
    output logic                  empty,
    input  logic                  pop,
    output coord_t                pixel_x,
    output coord_t                pixel_y,
    output logic [LEVEL_BITS-1:0] level,
    output logic                  line_done
);

    logic [LEVEL_BITS-1:0] level_reg;
    logic                  cmd_valid, cmd_pop;
    cmd_t                  cmd_head;
    div_req_t              div_req;
    div_rsp_t              div_rsp;
    logic                  out_full, out_wr;
    res_t                  out_data, rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= LEVEL_RESET;
        end
        else if (cfg_we)
        begin
            level_reg <= cfg_wdata;
        end
    end

    wual_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .command   (command),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .cmd_valid (cmd_valid),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop)
    );

    wual_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    wual_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_level (level_reg),
        .cmd_valid (cmd_valid),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_full  (out_full),
        .out_wr    (out_wr),
        .out_data  (out_data)
    );

    wual_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (out_wr),
        .wr_data  (out_data),
        .out_full (out_full),
        .empty    (empty),
        .pop      (pop),
        .rd_data  (rd_data)
    );

    assign pixel_x   = rd_data.x;
    assign pixel_y   = rd_data.y;
    assign level     = rd_data.lvl;
    assign line_done = rd_data.done;

    // back end never writes a beat into a full result queue
    a_no_out_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_wr |-> !out_full)
        else $error("result beat written into full queue");

    // back end only takes a command that is present
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    // divider reports a finished quotient for one cycle only
    a_div_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |=> !div_rsp.done)
        else $error("divider done held longer than one cycle");

    // a new division never starts while the previous result is being reported
    a_div_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.done)
        else $error("division started while a result was pending");

endmodule
